[rtl/assert_macros.svh]
// Assertion macros used by the tokenizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define CFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define CFT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/cft_pkg.sv]
// Types and constants shared by the CSV field tokenizer modules.
package cft_pkg;

  // Fixed character codes.
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_DELIM   = 2'd0;
  localparam logic [1:0] CFG_REC_END = 2'd1;
  localparam logic [1:0] CFG_COMMENT = 2'd2;
  localparam logic [7:0] DELIM_RST   = 8'd44;
  localparam logic [7:0] REC_END_RST = 8'd10;
  localparam logic [7:0] COMMENT_RST = 8'd35;

  // Kind of a result word.
  localparam logic EV_BYTE   = 1'b0;
  localparam logic EV_RECORD = 1'b1;

  // Kind of the quote that closed most recently and may still reopen.
  localparam logic [1:0] CQ_NONE   = 2'd0;
  localparam logic [1:0] CQ_SINGLE = 2'd1;
  localparam logic [1:0] CQ_DOUBLE = 2'd2;

  // Parser mode flags.
  typedef struct packed {
    logic       sq_open;
    logic       dq_open;
    logic       cmt_active;
    logic [1:0] closed_kind;
    logic       cmt_pending;
    logic       skip_white;
    logic       ovf_seen;
  } cft_mode_t;

  // Emission request from the parser to the emitter.
  typedef struct packed {
    logic start;  // an input word was taken
    logic fld;    // a non-empty field ends
    logic ovf;    // that field lost bytes
    logic rec;    // an end-of-record event follows
  } cft_req_t;

  // Emitter sequencer states.
  typedef enum logic [1:0] {
    E_IDLE,
    E_FIELD,
    E_REC
  } cft_emit_e;

endpackage

[rtl/cft_emit.sv]
// Field store memory, emission sequencer and output register stage.
module cft_emit import cft_pkg::*; #(
  parameter int FIELD_MAX = 32,
  localparam int LenW  = $clog2(FIELD_MAX + 1),
  localparam int AddrW = $clog2(FIELD_MAX)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cft_req_t         req_i,
  input  logic [LenW-1:0]  req_len_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  output logic             idle_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             event_kind_o,
  output logic [7:0]       field_byte_o,
  output logic             field_done_o,
  output logic             overflowed_o,
  output logic             run_last_o
);

  logic [7:0]       mem_q [FIELD_MAX];
  logic [7:0]       rdata_q;

  cft_emit_e        state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] last_idx_q, last_idx_d;
  logic             ovf_q, ovf_d;
  logic             rec_q, rec_d;

  // Read stage metadata, valid while its word waits for the output register.
  logic             rd_vld_q, rd_vld_d;
  logic             rd_kind_q, rd_done_q, rd_ovf_q, rd_last_q;
  logic             rd_kind_d, rd_done_d, rd_ovf_d, rd_last_d;

  logic             out_vld_q, out_vld_d;
  logic             out_kind_q, out_done_q, out_ovf_q, out_last_q;
  logic [7:0]       out_byte_q;

  logic             load;
  logic             issue;
  logic             rd_en;
  logic             at_last;

  assign load    = rd_vld_q && (!out_vld_q || out_ready_i);
  assign issue   = (state_q != E_IDLE) && (!rd_vld_q || load);
  assign at_last = (idx_q == last_idx_q);
  assign idle_o  = (state_q == E_IDLE);

  // Sequencer: one memory read or record token per issue slot.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    ovf_d      = ovf_q;
    rec_d      = rec_q;
    rd_en      = 1'b0;
    rd_kind_d  = rd_kind_q;
    rd_done_d  = rd_done_q;
    rd_ovf_d   = rd_ovf_q;
    rd_last_d  = rd_last_q;
    case (state_q)
      E_IDLE: begin
        if (req_i.start) begin
          idx_d      = '0;
          last_idx_d = AddrW'(req_len_i - LenW'(1));
          ovf_d      = req_i.ovf;
          rec_d      = req_i.rec;
          if (req_i.fld) begin
            state_d = E_FIELD;
          end else if (req_i.rec) begin
            state_d = E_REC;
          end
        end
      end
      E_FIELD: begin
        if (issue) begin
          rd_en     = 1'b1;
          rd_kind_d = EV_BYTE;
          rd_done_d = at_last;
          rd_ovf_d  = ovf_q;
          rd_last_d = at_last && !rec_q;
          idx_d     = idx_q + AddrW'(1);
          if (at_last) begin
            state_d = rec_q ? E_REC : E_IDLE;
          end
        end
      end
      E_REC: begin
        if (issue) begin
          rd_kind_d = EV_RECORD;
          rd_done_d = 1'b0;
          rd_ovf_d  = 1'b0;
          rd_last_d = 1'b1;
          state_d   = E_IDLE;
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  assign rd_vld_d  = issue || (rd_vld_q && !load);
  assign out_vld_d = load || (out_vld_q && !out_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= E_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Sequencer payload and read stage metadata.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
    ovf_q      <= ovf_d;
    rec_q      <= rec_d;
    rd_kind_q  <= rd_kind_d;
    rd_done_q  <= rd_done_d;
    rd_ovf_q   <= rd_ovf_d;
    rd_last_q  <= rd_last_d;
  end

  // Field store: written while idle, read only while emitting.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= rd_kind_q;
      out_byte_q <= (rd_kind_q == EV_RECORD) ? 8'd0 : rdata_q;
      out_done_q <= rd_done_q;
      out_ovf_q  <= rd_ovf_q;
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_kind_o = out_kind_q;
  assign field_byte_o = out_byte_q;
  assign field_done_o = out_done_q;
  assign overflowed_o = out_ovf_q;
  assign run_last_o   = out_last_q;

endmodule

[rtl/csv_field_tokenizer.sv]
// CSV field tokenizer top level: byte parser, mode registers and configuration.
// The first result of a word passes the sequencer state, the read stage and the output register.
// Throughput: a word without results is taken every cycle while the emitter is idle; a word
// with results holds the input while the sequencer reads the field store one byte a cycle unless the output stalls.
// Reset clears modes, length and flags and restores the configuration defaults;
// the field store is not cleared.
`include "assert_macros.svh"

module csv_field_tokenizer import cft_pkg::*; #(
  parameter int FIELD_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       has_byte_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       event_kind_o,
  output logic [7:0] field_byte_o,
  output logic       field_done_o,
  output logic       overflowed_o,
  output logic       run_last_o
);

  localparam int LenW  = $clog2(FIELD_MAX + 1);
  localparam int AddrW = $clog2(FIELD_MAX);

  logic [7:0]       delim_q, rec_end_q, comment_q;
  cft_mode_t        mode_q, mode_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  mark_q, mark_d;

  logic             accept;
  logic             emit_idle;
  cft_req_t         req;
  logic [LenW-1:0]  fld_len;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic             stop;
  logic             line_end;
  logic [7:0]       same_q8, other_q8;
  logic [7:0]       b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = emit_idle;
  assign accept      = in_valid_i && in_ready_o;
  assign b           = text_byte_i;
  assign line_end    = (b == rec_end_q) || (b == CH_LF) || (b == CH_CR);
  assign same_q8     = (mode_q.closed_kind == CQ_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
  assign other_q8    = (mode_q.closed_kind == CQ_SINGLE) ? CH_DQUOTE : CH_SQUOTE;

  // Byte parser: next modes, store write and emission request for one word.
  always_comb begin
    mode_d      = mode_q;
    len_d       = len_q;
    mark_d      = mark_q;
    wr_en       = 1'b0;
    wr_addr     = len_q[AddrW-1:0];
    fld_len     = len_q;
    req         = '0;
    req.start   = accept;
    stop        = 1'b0;

    if (has_byte_i) begin
      // Drop spaces and tabs after a space delimiter.
      if (mode_d.skip_white) begin
        if (b == CH_SPACE || b == CH_TAB) begin
          stop = 1'b1;
        end else begin
          mode_d.skip_white = 1'b0;
        end
      end

      // Tentative close after a quote ends a string.
      if (!stop) begin
        if (mode_d.closed_kind == CQ_SINGLE || mode_d.closed_kind == CQ_DOUBLE) begin
          if (mode_d.cmt_pending) begin
            if (b == delim_q || (b != same_q8 && line_end)) begin
              len_d                = mark_d;
              mode_d.cmt_active    = 1'b1;
              mode_d.cmt_pending   = 1'b0;
              mode_d.closed_kind   = CQ_NONE;
            end else if (b == same_q8) begin
              mode_d.cmt_pending = 1'b0;
              stop               = 1'b1;
            end else begin
              if (len_d < LenW'(FIELD_MAX)) begin
                wr_en   = 1'b1;
                wr_addr = len_d[AddrW-1:0];
                len_d   = len_d + LenW'(1);
              end else begin
                mode_d.ovf_seen = 1'b1;
              end
              stop = 1'b1;
            end
          end else if (b == delim_q || b == other_q8 || line_end) begin
            mode_d.closed_kind = CQ_NONE;
          end else if (b == same_q8) begin
            stop = 1'b1;
          end else if (b == comment_q) begin
            mode_d.cmt_pending = 1'b1;
            mark_d             = len_d;
            if (len_d < LenW'(FIELD_MAX)) begin
              wr_en   = 1'b1;
              wr_addr = len_d[AddrW-1:0];
              len_d   = len_d + LenW'(1);
            end else begin
              mode_d.ovf_seen = 1'b1;
            end
            stop = 1'b1;
          end
        end else begin
          mode_d.closed_kind = CQ_NONE;
        end
      end

      // Main byte classification.
      if (!stop) begin
        if (b == CH_SQUOTE && !mode_d.dq_open && !mode_d.cmt_active) begin
          if (!mode_d.sq_open) begin
            mode_d.sq_open = 1'b1;
          end else begin
            mode_d.sq_open     = 1'b0;
            mode_d.closed_kind = CQ_SINGLE;
          end
        end else if (b == CH_DQUOTE && !mode_d.sq_open && !mode_d.cmt_active) begin
          if (!mode_d.dq_open) begin
            mode_d.dq_open = 1'b1;
          end else begin
            mode_d.dq_open     = 1'b0;
            mode_d.closed_kind = CQ_DOUBLE;
          end
        end else if (b == comment_q && !mode_d.sq_open && !mode_d.dq_open) begin
          mode_d.cmt_active = 1'b1;
        end else if (b == delim_q && !mode_d.sq_open && !mode_d.dq_open &&
                     !mode_d.cmt_active) begin
          req.fld         = (len_d != '0);
          req.ovf         = mode_d.ovf_seen;
          fld_len         = len_d;
          len_d           = '0;
          mode_d.ovf_seen = 1'b0;
          if (delim_q == CH_SPACE) begin
            mode_d.skip_white = 1'b1;
          end
        end else if (b == rec_end_q) begin
          mode_d.sq_open    = 1'b0;
          mode_d.dq_open    = 1'b0;
          mode_d.cmt_active = 1'b0;
          req.fld           = (len_d != '0);
          req.ovf           = mode_d.ovf_seen;
          req.rec           = 1'b1;
          fld_len           = len_d;
          len_d             = '0;
          mode_d.ovf_seen   = 1'b0;
        end else if (b == CH_LF || b == CH_CR) begin
          mode_d.cmt_active = 1'b0;
          req.fld           = (len_d != '0);
          req.ovf           = mode_d.ovf_seen;
          fld_len           = len_d;
          len_d             = '0;
          mode_d.ovf_seen   = 1'b0;
        end else if (!mode_d.cmt_active) begin
          if (len_d < LenW'(FIELD_MAX)) begin
            wr_en   = 1'b1;
            wr_addr = len_d[AddrW-1:0];
            len_d   = len_d + LenW'(1);
          end else begin
            mode_d.ovf_seen = 1'b1;
          end
        end
      end
    end

    // Stream end: settle a pending comment and flush a non-empty field.
    if (end_of_stream_i) begin
      if (mode_d.cmt_pending) begin
        len_d              = mark_d;
        mode_d.cmt_active  = 1'b1;
        mode_d.cmt_pending = 1'b0;
      end
      mode_d.closed_kind = CQ_NONE;
      mode_d.skip_white  = 1'b0;
      if (len_d != '0) begin
        req.fld         = 1'b1;
        req.ovf         = mode_d.ovf_seen;
        req.rec         = 1'b1;
        fld_len         = len_d;
        len_d           = '0;
        mode_d.ovf_seen = 1'b0;
      end
    end

    if (!accept) begin
      wr_en = 1'b0;
    end
  end

  // Mode, length and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      len_q     <= '0;
      mark_q    <= '0;
      delim_q   <= DELIM_RST;
      rec_end_q <= REC_END_RST;
      comment_q <= COMMENT_RST;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        mark_q <= mark_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DELIM:   delim_q   <= cfg_data_i;
          CFG_REC_END: rec_end_q <= cfg_data_i;
          CFG_COMMENT: comment_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  cft_emit #(
    .FIELD_MAX(FIELD_MAX)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .req_len_i    (fld_len),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (text_byte_i),
    .idle_o       (emit_idle),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .field_byte_o (field_byte_o),
    .field_done_o (field_done_o),
    .overflowed_o (overflowed_o),
    .run_last_o   (run_last_o)
  );

  // The field never grows past the store.
  `CFT_ASSERT(a_len_bound, len_q <= LenW'(FIELD_MAX), "field length exceeds store")
  // A pending comment only exists during a tentative close.
  `CFT_ASSERT_IMPL(a_pend_kind, mode_q.cmt_pending,
                   mode_q.closed_kind == CQ_SINGLE || mode_q.closed_kind == CQ_DOUBLE,
                   "pending comment without a closed quote")
  // The cut-back mark of a pending comment lies inside the field.
  `CFT_ASSERT_IMPL(a_mark_bound, mode_q.cmt_pending, mark_q <= len_q,
                   "pending comment mark beyond field length")

endmodule

[sim/csv_field_tokenizer_tb.sv]
// Self-checking testbench for the CSV field tokenizer with a scoreboard and a predictor.
module csv_field_tokenizer_tb import cft_pkg::*; ();

  localparam int FIELD_MAX     = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DIR_N         = 24;

  // One result word as it leaves the block.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       done;
    logic       ovf;
    logic       last;
  } token_t;

  // One directed input word, with its results typed in where they are obvious.
  typedef struct packed {
    logic             hb;
    logic [7:0]       ch;
    logic             eos;
    logic             typed;
    logic [1:0]       n_tok;
    token_t [0:2]     tok;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // A plain field ended by the delimiter, then an empty field.
    '{1'b1, 8'h61, 1'b0, 1'b1, 2'd0, '0},
    '{1'b1, DELIM_RST, 1'b0, 1'b1, 2'd1,
      '{'{EV_BYTE, 8'h61, 1'b1, 1'b0, 1'b1}, '0, '0}},
    '{1'b1, DELIM_RST, 1'b0, 1'b1, 2'd0, '0},
    // Extreme byte values, closed by the record end.
    '{1'b1, 8'hFF, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, 8'h00, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_LF, 1'b0, 1'b1, 2'd3,
      '{'{EV_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{EV_BYTE, 8'h00, 1'b1, 1'b0, 1'b0},
        '{EV_RECORD, 8'h00, 1'b0, 1'b0, 1'b1}}},
    // Delimiter and comment inside a string, then a doubled quote.
    '{1'b1, CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, DELIM_RST, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, COMMENT_RST, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    // A pending comment cancelled by a quote, then one confirmed by a delimiter.
    '{1'b1, COMMENT_RST, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, 8'h78, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, COMMENT_RST, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, 8'h79, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, DELIM_RST, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_CR, 1'b0, 1'b0, 2'd0, '0},
    // The other quote kind ends a tentative close and opens its own string.
    '{1'b1, CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    '{1'b1, CH_SQUOTE, 1'b0, 1'b0, 2'd0, '0},
    // Stream end flushes the field; a bare flush with nothing stored is silent.
    '{1'b1, 8'h80, 1'b1, 1'b1, 2'd2,
      '{'{EV_BYTE, 8'h80, 1'b1, 1'b0, 1'b0},
        '{EV_RECORD, 8'h00, 1'b0, 1'b0, 1'b1}, '0}},
    '{1'b0, 8'h00, 1'b1, 1'b1, 2'd0, '0},
    '{1'b1, CH_LF, 1'b0, 1'b1, 2'd1,
      '{'{EV_RECORD, 8'h00, 1'b0, 1'b0, 1'b1}, '0, '0}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       has_byte_i;
  logic [7:0] text_byte_i;
  logic       end_of_stream_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       event_kind_o;
  logic [7:0] field_byte_o;
  logic       field_done_o;
  logic       overflowed_o;
  logic       run_last_o;

  // Traffic shaping shared by the sender and the receiver.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_rx     = 1'b0;

  // Scoreboard bookkeeping.
  token_t tokens_due [$];
  token_t step_toks [$];
  int     errors      = 0;
  int     words_taken = 0;
  int     quiet       = 0;

  // Predictor copy of the configuration and the parser state.
  logic [7:0] cfg_dlm = DELIM_RST;
  logic [7:0] cfg_rec = REC_END_RST;
  logic [7:0] cfg_cmt = COMMENT_RST;
  logic [7:0] fld_buf [FIELD_MAX];
  int         fld_len      = 0;
  int         pend_mark    = 0;
  logic [1:0] closed_quote = CQ_NONE;
  bit         sq_open      = 1'b0;
  bit         dq_open      = 1'b0;
  bit         cmt_on       = 1'b0;
  bit         cmt_pend     = 1'b0;
  bit         skip_ws      = 1'b0;
  bit         ovf_flag     = 1'b0;

  csv_field_tokenizer #(.FIELD_MAX(FIELD_MAX)) uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor helpers.
  function automatic void add_token(logic kind, logic [7:0] data, logic done, logic ovf);
    step_toks.push_back('{kind, data, done, ovf, 1'b0});
  endfunction

  function automatic void store_char(logic [7:0] ch);
    if (fld_len < FIELD_MAX) begin
      fld_buf[fld_len] = ch;
      fld_len++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  function automatic void flush_field();
    for (int i = 0; i < fld_len; i++) begin
      add_token(EV_BYTE, fld_buf[i], i + 1 == fld_len, ovf_flag);
    end
    fld_len  = 0;
    ovf_flag = 1'b0;
  endfunction

  function automatic bit line_end(logic [7:0] ch);
    return ch == cfg_rec || ch == CH_LF || ch == CH_CR;
  endfunction

  function automatic void commit_comment();
    fld_len      = pend_mark;
    cmt_on       = 1'b1;
    cmt_pend     = 1'b0;
    closed_quote = CQ_NONE;
  endfunction

  // Parses one text byte and adds the results it causes.
  function automatic void tokenize_char(logic [7:0] ch);
    logic [7:0] same_q;
    logic [7:0] other_q;
    if (skip_ws) begin
      if (ch == CH_SPACE || ch == CH_TAB) return;
      skip_ws = 1'b0;
    end
    // A recently closed quote may still be doubled or carry a pending comment.
    if (closed_quote == CQ_SINGLE || closed_quote == CQ_DOUBLE) begin
      same_q  = (closed_quote == CQ_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
      other_q = (closed_quote == CQ_SINGLE) ? CH_DQUOTE : CH_SQUOTE;
      if (cmt_pend) begin
        if (ch == cfg_dlm) begin
          commit_comment();
        end else if (ch == same_q) begin
          cmt_pend = 1'b0;
          return;
        end else if (line_end(ch)) begin
          commit_comment();
        end else begin
          store_char(ch);
          return;
        end
      end else if (ch == cfg_dlm || ch == other_q || line_end(ch)) begin
        closed_quote = CQ_NONE;
      end else if (ch == same_q) begin
        return;
      end else if (ch == cfg_cmt) begin
        cmt_pend  = 1'b1;
        pend_mark = fld_len;
        store_char(ch);
        return;
      end
    end else begin
      closed_quote = CQ_NONE;
    end
    // Normal handling of the byte.
    if (ch == CH_SQUOTE && !dq_open && !cmt_on) begin
      if (!sq_open) begin
        sq_open = 1'b1;
      end else begin
        sq_open      = 1'b0;
        closed_quote = CQ_SINGLE;
      end
    end else if (ch == CH_DQUOTE && !sq_open && !cmt_on) begin
      if (!dq_open) begin
        dq_open = 1'b1;
      end else begin
        dq_open      = 1'b0;
        closed_quote = CQ_DOUBLE;
      end
    end else if (ch == cfg_cmt && !sq_open && !dq_open) begin
      cmt_on = 1'b1;
    end else if (ch == cfg_dlm && !sq_open && !dq_open && !cmt_on) begin
      flush_field();
      if (cfg_dlm == CH_SPACE) skip_ws = 1'b1;
    end else if (ch == cfg_rec) begin
      sq_open = 1'b0;
      dq_open = 1'b0;
      cmt_on  = 1'b0;
      flush_field();
      add_token(EV_RECORD, 8'h00, 1'b0, 1'b0);
    end else if (ch == CH_LF || ch == CH_CR) begin
      cmt_on = 1'b0;
      flush_field();
    end else if (!cmt_on) begin
      store_char(ch);
    end
  endfunction

  // Works out the results of one input word into step_toks.
  function automatic void tokenize_word(logic hb, logic [7:0] ch, logic eos);
    token_t t;
    step_toks.delete();
    if (hb) tokenize_char(ch);
    if (eos) begin
      if (cmt_pend) commit_comment();
      closed_quote = CQ_NONE;
      skip_ws      = 1'b0;
      if (fld_len > 0) begin
        flush_field();
        add_token(EV_RECORD, 8'h00, 1'b0, 1'b0);
      end
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Scoreboard: checks results against the oldest expectation, then predicts new words.
  always @(posedge clk_i) begin : scoreboard
    token_t got;
    token_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{event_kind_o, field_byte_o, field_done_o, overflowed_o, run_last_o};
        if (tokens_due.size() == 0) begin
          note_error($sformatf("result word with nothing expected: kind %0d byte %02h",
                               got.kind, got.data));
        end else begin
          want = tokens_due.pop_front();
          if (got != want) begin
            note_error($sformatf({"mismatch: expected kind %0d byte %02h done %0d ovf %0d ",
                                  "last %0d, got kind %0d byte %02h done %0d ovf %0d last %0d"},
                                 want.kind, want.data, want.done, want.ovf, want.last,
                                 got.kind, got.data, got.done, got.ovf, got.last));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        tokenize_word(has_byte_i, text_byte_i, end_of_stream_i);
        if (words_taken < DIR_N && DIR_TAB[words_taken].typed) begin
          for (int i = 0; i < DIR_TAB[words_taken].n_tok; i++) begin
            tokens_due.push_back(DIR_TAB[words_taken].tok[i]);
          end
        end else begin
          foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
        end
        words_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DELIM:   cfg_dlm = cfg_data_i;
          CFG_REC_END: cfg_rec = cfg_data_i;
          CFG_COMMENT: cfg_cmt = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= STALL_LIMIT) begin
        $display("csv_field_tokenizer regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked for.
  always begin : receiver
    @(posedge clk_i);
    if (hold_rx) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_rx = 1'b0;
    end
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offers one input word after a random gap and waits until it is taken.
  task automatic send_word(input logic hb, input logic [7:0] ch, input logic eos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    has_byte_i      <= hb;
    text_byte_i     <= ch;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes all three registers while the block is idle.
  task automatic set_config(input logic [7:0] dlm, input logic [7:0] rec,
                            input logic [7:0] cmt);
    wait_idle();
    write_reg(CFG_DELIM, dlm);
    write_reg(CFG_REC_END, rec);
    write_reg(CFG_COMMENT, cmt);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks a text byte, weighted toward the characters that steer the parser.
  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(99);
    if (sel < 38) return 8'($urandom_range(8'h61, 8'h7A));
    else if (sel < 46) return cfg_dlm;
    else if (sel < 52) return cfg_rec;
    else if (sel < 56) return CH_LF;
    else if (sel < 59) return CH_CR;
    else if (sel < 65) return CH_DQUOTE;
    else if (sel < 71) return CH_SQUOTE;
    else if (sel < 76) return cfg_cmt;
    else if (sel < 80) return CH_SPACE;
    else if (sel < 83) return CH_TAB;
    else return 8'($urandom);
  endfunction

  // Random text with occasional long fields, bare flushes and stream ends.
  task automatic send_text(input int n);
    int   sent;
    int   run;
    logic hb;
    logic eos;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 3) begin
        // A long field that may run past the end of the store.
        run = $urandom_range(FIELD_MAX - 4, FIELD_MAX + 8);
        repeat (run) send_word(1'b1, 8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        send_word(1'b1, cfg_dlm, 1'b0);
        sent += run + 1;
      end else begin
        hb  = ($urandom_range(99) >= 4);
        eos = ($urandom_range(99) < 4);
        send_word(hb, pick_char(), eos);
        sent++;
      end
    end
  endtask

  // Main sequence: reset, directed words, then random text under several settings.
  initial begin : stimulus
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_DELIM;
    cfg_data_i      = 8'h00;
    in_valid_i      = 1'b0;
    has_byte_i      = 1'b0;
    text_byte_i     = 8'h00;
    end_of_stream_i = 1'b0;
    out_ready_i     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 29;
    rx_idle_pct = 56;
    for (int i = 0; i < DIR_N; i++) begin
      send_word(DIR_TAB[i].hb, DIR_TAB[i].ch, DIR_TAB[i].eos);
    end
    send_text(40);

    // The receiver holds off while an overflowing field fills the block.
    send_word(1'b1, CH_LF, 1'b0);
    hold_rx = 1'b1;
    repeat (FIELD_MAX + 8) send_word(1'b1, 8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    send_word(1'b1, cfg_dlm, 1'b0);
    send_word(1'b1, 8'h62, 1'b0);
    send_word(1'b1, CH_LF, 1'b0);
    send_word(1'b1, 8'h63, 1'b1);

    set_config(CH_SPACE, CH_LF, 8'hFF);
    send_text(40);

    tx_idle_pct = 56;
    rx_idle_pct = 29;
    set_config(8'hFF, 8'h00, 8'h2F);
    send_text(40);
    set_config(CH_TAB, 8'h3B, 8'h00);
    send_text(40);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(8'h00, 8'hFF, COMMENT_RST);
    send_text(40);

    wait_idle();
    errors += tokens_due.size();
    if (errors == 0) begin
      $display("csv_field_tokenizer regression: pass");
    end else begin
      $display("csv_field_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
